>>> rtl/rbff_pkg.sv
// Package for the range bitmap first-free block: sizes and command codes.
package rbff_pkg;
    localparam int SLOTS_DEF      = 4096;
    localparam int BLOCK_BITS_DEF = 64;
    localparam int CMD_W          = 2;
    localparam int SLOT_W         = 12;

    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVERT = 2'd2;
endpackage

>>> rtl/range_bitmap_first_free.sv
// Range bitmap with per-block lazy tags, range set/clear/invert and first-free search.
//
// The map holds SLOTS one-bit slots in blocks of BLOCK_BITS. Block words live in one
// synchronous memory (registered read); the full/empty/flip tags are flip-flops, one
// of each per block, reset so every block is tagged empty; the map is empty straight
// out of reset and the word memory needs no clearing pass. A request walks its blocks
// one at a time: a block the range covers whole only has its tags changed; a block it
// covers in part is read, resolved from its tags, modified and written back. Then a
// scan visits blocks from zero: full blocks are passed over, the first non-full block
// is read and resolved from its tags, and the lowest zero is found with a priority
// search over that word. The time a request takes is bounded by the block-at-a-time
// walk over the tag file and the single memory port. One request is handled at a
// time; the result sits in an output register and the next request is taken once it
// has left.
module range_bitmap_first_free #(
    parameter int SLOTS      = rbff_pkg::SLOTS_DEF,
    parameter int BLOCK_BITS = rbff_pkg::BLOCK_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rbff_pkg::CMD_W-1:0]  i_command,
    input  logic [rbff_pkg::SLOT_W-1:0] i_range_low,
    input  logic [rbff_pkg::SLOT_W-1:0] i_range_high,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rbff_pkg::SLOT_W-1:0] o_first_free,
    output logic                        o_all_full
);
    localparam int NBLOCKS = (SLOTS + BLOCK_BITS - 1) / BLOCK_BITS;
    localparam int BW      = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int KW      = $clog2(BLOCK_BITS);
    localparam int SW      = $clog2(SLOTS + 1);
    localparam int LASTCNT = SLOTS - (NBLOCKS - 1) * BLOCK_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_URD   = 3'd2;
    localparam logic [2:0] S_UWR   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_SRD   = 3'd5;
    localparam logic [2:0] S_SFIND = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [BLOCK_BITS-1:0] r_mem [NBLOCKS];
    logic [BLOCK_BITS-1:0] r_rdata;
    logic [NBLOCKS-1:0]    r_full, r_empty, r_flip;

    logic [2:0]                  r_state;
    logic [rbff_pkg::CMD_W-1:0]  r_cmd;
    logic [SW-1:0]               r_lo, r_hi;
    logic [BW-1:0]               r_blk, r_blk_last;
    logic [BLOCK_BITS-1:0]       r_mask, r_word;
    logic [rbff_pkg::SLOT_W-1:0] r_first;
    logic                        r_afull;

    // valid mask of a block, short for the last one
    function automatic logic [BLOCK_BITS-1:0] vmask(input logic [BW-1:0] b);
        logic [BLOCK_BITS-1:0] m;
        m = '1;
        if (32'(b) == NBLOCKS - 1)
            m = {BLOCK_BITS{1'b1}} >> (BLOCK_BITS - LASTCNT);
        return m;
    endfunction

    // range mask within block b
    logic [SW+BW:0]          c_base;
    logic [KW-1:0]           c_first, c_last;
    logic [BLOCK_BITS-1:0]   c_m, c_v;
    always_comb begin
        c_base = (SW+BW+1)'(r_blk) * (SW+BW+1)'(BLOCK_BITS);
        c_first = ((SW+BW+1)'(r_lo) > c_base) ? KW'((SW+BW+1)'(r_lo) - c_base) : '0;
        c_last  = ((SW+BW+1)'(r_hi) - c_base < (SW+BW+1)'(BLOCK_BITS))
                ? KW'((SW+BW+1)'(r_hi) - c_base) : KW'(BLOCK_BITS - 1);
        c_v = vmask(r_blk);
        c_m = (({BLOCK_BITS{1'b1}} >> (KW'(BLOCK_BITS - 1) - (c_last - c_first)))
               << c_first) & c_v;
    end

    // word resolved from tags; r_rdata when memory read is needed
    logic [BLOCK_BITS-1:0] c_res, c_mod, c_z;
    always_comb begin
        if (r_empty[r_blk])     c_res = '0;
        else if (r_full[r_blk]) c_res = c_v;
        else if (r_flip[r_blk]) c_res = (r_rdata ^ c_v) & c_v;
        else                    c_res = r_rdata & c_v;
        case (r_cmd)
            rbff_pkg::CMD_SET:   c_mod = c_res | r_mask;
            rbff_pkg::CMD_CLEAR: c_mod = c_res & ~r_mask;
            default:             c_mod = c_res ^ r_mask;
        endcase
        c_z = ~r_word & c_v;
    end

    logic [KW-1:0] c_k;
    always_comb begin
        c_k = '0;
        for (int k = BLOCK_BITS - 1; k >= 0; k--)
            if (c_z[k]) c_k = KW'(k);
    end

    logic c_take;
    logic [SW-1:0] c_lo, c_hi;
    assign c_take = i_valid && !o_stall;
    assign c_lo = SW'(i_range_low);
    assign c_hi = (32'(i_range_high) >= SLOTS) ? SW'(SLOTS - 1) : SW'(i_range_high);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_blk];
        if (r_state == S_UWR) r_mem[r_blk] <= c_mod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= '0;
            r_empty <= '1;
            r_flip  <= '0;
            r_blk   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (c_take) begin
                        r_cmd <= i_command;
                        r_lo  <= c_lo;
                        r_hi  <= c_hi;
                        r_blk_last <= BW'(c_hi / BLOCK_BITS);
                        if (i_command <= rbff_pkg::CMD_INVERT && i_range_low <= i_range_high
                            && 32'(i_range_low) < SLOTS) begin
                            r_blk   <= BW'(c_lo / BLOCK_BITS);
                            r_state <= S_UPD;
                        end else begin
                            r_blk   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_UPD: begin
                    r_mask <= c_m;
                    if (c_m == c_v) begin
                        case (r_cmd)
                            rbff_pkg::CMD_SET: begin
                                r_full[r_blk] <= 1'b1; r_empty[r_blk] <= 1'b0;
                                r_flip[r_blk] <= 1'b0;
                            end
                            rbff_pkg::CMD_CLEAR: begin
                                r_full[r_blk] <= 1'b0; r_empty[r_blk] <= 1'b1;
                                r_flip[r_blk] <= 1'b0;
                            end
                            default: begin
                                if (r_full[r_blk] || r_empty[r_blk]) begin
                                    r_full[r_blk]  <= r_empty[r_blk];
                                    r_empty[r_blk] <= r_full[r_blk];
                                end else
                                    r_flip[r_blk] <= !r_flip[r_blk];
                            end
                        endcase
                        if (r_blk == r_blk_last) begin
                            r_blk <= '0; r_state <= S_SCAN;
                        end else
                            r_blk <= r_blk + 1'b1;
                    end else
                        r_state <= S_URD;
                end
                S_URD: r_state <= S_UWR;
                S_UWR: begin
                    // write back modified word and retag
                    r_full[r_blk]  <= (c_mod == c_v);
                    r_empty[r_blk] <= (c_mod == '0);
                    r_flip[r_blk]  <= 1'b0;
                    if (r_blk == r_blk_last) begin
                        r_blk <= '0; r_state <= S_SCAN;
                    end else begin
                        r_blk <= r_blk + 1'b1; r_state <= S_UPD;
                    end
                end
                S_SCAN: begin
                    if (!r_full[r_blk]) r_state <= S_SRD;
                    else if (32'(r_blk) == NBLOCKS - 1) begin
                        r_first <= '0; r_afull <= 1'b1; r_state <= S_OUT;
                    end else
                        r_blk <= r_blk + 1'b1;
                end
                S_SRD: begin
                    // wait for the read; resolution applies the block's full/empty/flip tags to the word
                    r_word  <= c_res;
                    r_state <= S_SFIND;
                end
                S_SFIND: begin
                    r_first <= rbff_pkg::SLOT_W'((SW+BW+1)'(c_base) + (SW+BW+1)'(c_k));
                    r_afull <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_first_free = r_first;
    assign o_all_full   = r_afull;

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_full[r_blk] && r_empty[r_blk] && BLOCK_BITS > 0 && r_state == S_SCAN))
        else $error("block tagged both full and empty");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_first_free) && $stable(o_all_full)))
        else $error("result changed while stalled");
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_all_full) |-> (o_first_free == '0))
        else $error("full map reports nonzero slot");
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UWR) |-> $past(r_state) == S_URD)
        else $error("write back without a read");
endmodule

>>> tb/sv/tb_range_bitmap_first_free.sv
// Testbench for range_bitmap_first_free: random range requests checked against a bitmap model.
`timescale 1ns / 100ps

module tb_range_bitmap_first_free;
    localparam int NSLOTS      = rbff_pkg::SLOTS_DEF;
    localparam int CMD_W       = rbff_pkg::CMD_W;
    localparam int SLOT_W      = rbff_pkg::SLOT_W;
    localparam int CYCLE_LIMIT = 1000000;

    // command code with no effect on the map
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] lo;
        logic [SLOT_W-1:0] hi;
    } t_request;

    typedef struct packed {
        logic [SLOT_W-1:0] first_free;
        logic              all_full;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command;
    logic [SLOT_W-1:0] i_range_low;
    logic [SLOT_W-1:0] i_range_high;
    logic              o_valid;
    logic              i_stall;
    logic [SLOT_W-1:0] o_first_free;
    logic              o_all_full;

    range_bitmap_first_free uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_first_free (o_first_free),
        .o_all_full   (o_all_full)
    );

    // Flat bitmap: the lazy tags of the block are invisible from outside, so a plain
    // bit per slot gives the same answers.
    logic [NSLOTS-1:0] slot_map;
    t_request          pending_reqs[$];
    t_answer           expected_answers[$];
    int                errors;
    int                cycles;
    bit                stim_done;
    bit                hold_sender;   // sender pauses while set
    bit                long_hold_req; // asks the receiver for one long hold-off
    int                hold_left;
    int                gap_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Apply one request to the bitmap and return the lowest clear slot.
    function automatic t_answer apply_request(t_request rq);
        t_answer a;
        int      top;
        if (rq.command <= rbff_pkg::CMD_INVERT && rq.lo <= rq.hi && int'(rq.lo) < NSLOTS) begin
            top = (int'(rq.hi) >= NSLOTS) ? NSLOTS - 1 : int'(rq.hi);
            for (int s = int'(rq.lo); s <= top; s++) begin
                case (rq.command)
                    rbff_pkg::CMD_SET:   slot_map[s] = 1'b1;
                    rbff_pkg::CMD_CLEAR: slot_map[s] = 1'b0;
                    default:             slot_map[s] = ~slot_map[s];
                endcase
            end
        end
        a.first_free = '0;
        a.all_full   = 1'b1;
        for (int s = 0; s < NSLOTS; s++) begin
            if (!slot_map[s]) begin
                a.first_free = s[SLOT_W-1:0];
                a.all_full   = 1'b0;
                break;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    task automatic add_req(logic [CMD_W-1:0] c, int lo, int hi);
        t_request rq;
        rq.command = c;
        rq.lo      = lo[SLOT_W-1:0];
        rq.hi      = hi[SLOT_W-1:0];
        pending_reqs.push_back(rq);
    endtask

    // Random range: mostly short or block-aligned spans so partial and whole blocks mix.
    task automatic add_random_req();
        int lo, hi, k;
        logic [CMD_W-1:0] c;
        k = $urandom_range(0, 99);
        c = (k < 3) ? CMD_SPARE : CMD_W'($urandom_range(0, 2));
        lo = $urandom_range(0, NSLOTS - 1);
        k = $urandom_range(0, 99);
        if (k < 40)      hi = lo + $urandom_range(0, 70);
        else if (k < 60) begin
            lo = (lo / 64) * 64;
            hi = lo + 64 * $urandom_range(1, 8) - 1;
        end else if (k < 90) hi = lo + $urandom_range(0, 1200);
        else             hi = $urandom_range(0, NSLOTS - 1); // includes empty ranges
        if (hi > NSLOTS - 1) hi = NSLOTS - 1;
        // Bias toward setting low slots so the full map and deep scans appear.
        if ($urandom_range(0, 9) == 0) begin
            c = rbff_pkg::CMD_SET;
            lo = 0;
            hi = $urandom_range(NSLOTS - 200, NSLOTS - 1);
        end
        add_req(c, lo, hi);
    endtask

    // Driver: change inputs on the falling edge; hold the request while stalled.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall) begin
            // hold the stalled request unchanged
        end else begin
            if (i_valid) void'(pending_reqs.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (!hold_sender && pending_reqs.size() > 0) begin
                i_valid      <= 1'b1;
                i_command    <= pending_reqs[0].command;
                i_range_low  <= pending_reqs[0].lo;
                i_range_high <= pending_reqs[0].hi;
                gap_left     <= gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (long_hold_req && hold_left == 0) begin
            hold_left     <= 400;
            long_hold_req <= 1'b0;
            i_stall       <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else if (hold_left == 1) begin
            hold_left <= 0;
            i_stall   <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 25) || (gap_len() > 9);
        end
    end

    // Monitor: predict on accepted requests, check accepted answers.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (i_valid && !o_stall)
                expected_answers.push_back(apply_request({i_command, i_range_low,
                                                          i_range_high}));
            if (o_valid && !i_stall) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected answer, first_free", o_first_free, -1);
                end else begin
                    want = expected_answers.pop_front();
                    if (o_all_full !== want.all_full)
                        report_mismatch("all_full", o_all_full, want.all_full);
                    if (o_first_free !== want.first_free)
                        report_mismatch("first_free", o_first_free, want.first_free);
                end
            end
        end
    end

    // Timeout watch.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_range_bitmap_first_free: errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_answers.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        slot_map      = '0;
        errors        = 0;
        cycles        = 0;
        stim_done     = 0;
        hold_sender   = 1'b1;
        long_hold_req = 1'b0;
        hold_left     = 0;
        gap_left      = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_command     = rbff_pkg::CMD_SET;
        i_range_low   = '0;
        i_range_high  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, each command, empty range, unused command, full map.
        add_req(rbff_pkg::CMD_SET, 0, 0);
        add_req(rbff_pkg::CMD_SET, 4095, 4095);
        add_req(rbff_pkg::CMD_INVERT, 0, 4095);
        add_req(rbff_pkg::CMD_CLEAR, 100, 99);
        add_req(CMD_SPARE, 0, 4095);
        add_req(rbff_pkg::CMD_SET, 0, 4095);
        add_req(rbff_pkg::CMD_CLEAR, 4095, 4095);
        add_req(rbff_pkg::CMD_INVERT, 64, 191);
        add_req(rbff_pkg::CMD_INVERT, 63, 64);
        add_req(rbff_pkg::CMD_CLEAR, 0, 4095);
        add_req(rbff_pkg::CMD_SET, 0, 62);
        add_req(rbff_pkg::CMD_SET, 63, 127);
        add_req(rbff_pkg::CMD_INVERT, 128, 255);
        add_req(rbff_pkg::CMD_INVERT, 130, 200);
        add_req(rbff_pkg::CMD_INVERT, 128, 255);
        add_req(rbff_pkg::CMD_SET, 2730, 1365);
        add_req(rbff_pkg::CMD_SET, 1365, 2730);
        add_req(rbff_pkg::CMD_INVERT, 2730, 4095);
        add_req(rbff_pkg::CMD_SET, 0, 4095);
        add_req(rbff_pkg::CMD_INVERT, 0, 4095);
        hold_sender = 1'b0;

        // Pressure: receiver holds off for a long stretch while requests keep coming.
        wait_drained();
        long_hold_req = 1'b1;
        for (int n = 0; n < 30; n++) add_random_req();
        wait_drained();

        for (int n = 0; n < 950; n++) begin
            add_random_req();
            if (n == 500) begin
                // Sender pauses until every expected answer has come.
                wait_drained();
            end
            while (pending_reqs.size() > 8) @(posedge i_clk);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (errors == 0 && expected_answers.size() == 0) begin
            $display("tb_range_bitmap_first_free: clean");
        end else begin
            $display("tb_range_bitmap_first_free: errors");
        end
        $finish;
    end
endmodule
